/* rtl/vtp_pkg.sv */
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants of the vertex transform block.
// ----------------------------------------------------------------------------
package vtp_pkg;

	localparam int NUM_PAIRS = 8;
	localparam int NUM_ROWS  = 4;
	localparam int NUM_LANES = 3;
	localparam int W_ROW     = 3;
	localparam int COORD_W   = 32;
	localparam int PAIR_W    = 64;
	localparam int IDX_W     = 3;
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 66;
	localparam int MAG_W     = 65;
	localparam int QUO_W     = 32;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = 3;

	localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7fff_ffff;
	localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef enum logic {
		CMD_FULL   = 1'b0,
		CMD_ROTATE = 1'b1
	} cmd_t;

	// Word between front and back: row sums, w in row W_ROW.
	typedef struct packed {
		cmd_t                          cmd;
		logic [NUM_ROWS-1:0][ACC_W-1:0] sum;
	} sums_t;

	// One stage of the divider pipeline.
	typedef struct packed {
		cmd_t                            cmd;
		logic                            wzero;
		logic [NUM_LANES-1:0]            neg;
		logic [NUM_LANES-1:0]            ovf;
		logic [NUM_LANES-1:0][MAG_W-1:0] mag;
		logic [NUM_LANES-1:0][MAG_W-1:0] rem;
		logic [NUM_LANES-1:0][QUO_W-1:0] quo;
		logic [MAG_W-1:0]                den;
	} div_t;

endpackage

/* rtl/vtp_if.sv */
// ----------------------------------------------------------------------------
// vtp_in_if / vtp_out_if
// Valid/ready channels carrying vertices in and transformed vertices out.
// ----------------------------------------------------------------------------
interface vtp_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] vertex_x;
	logic [31:0] vertex_y;
	logic [31:0] vertex_z;

	modport source (output valid, command, vertex_x, vertex_y, vertex_z, input ready);
	modport sink   (input valid, command, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface vtp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic        divide_by_zero;
	logic        saturated;

	modport source (output valid, out_x, out_y, out_z, divide_by_zero, saturated,
		input ready);
	modport sink   (input valid, out_x, out_y, out_z, divide_by_zero, saturated,
		output ready);
endinterface

/* rtl/vtp_front.sv */
// ----------------------------------------------------------------------------
// vtp_front
// Accepts vertices, forms the twelve products and the four row sums.
// ----------------------------------------------------------------------------
module vtp_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	vtp_in_if.sink                                          vtx,
	input  logic [vtp_pkg::NUM_ROWS*vtp_pkg::NUM_ROWS-1:0][vtp_pkg::COORD_W-1:0] matrix,
	output logic                                            push,
	output vtp_pkg::sums_t                                  push_word,
	input  logic                                            full
);

	logic adv;
	logic v_s1, v_s2;
	vtp_pkg::cmd_t cmd_s1;
	logic signed [vtp_pkg::PROD_W-1:0] prod_s1 [vtp_pkg::NUM_ROWS][vtp_pkg::NUM_LANES];
	logic signed [vtp_pkg::COORD_W-1:0] trans_s1 [vtp_pkg::NUM_ROWS];
	vtp_pkg::sums_t word_s2;
	logic signed [vtp_pkg::COORD_W-1:0] vin [vtp_pkg::NUM_LANES];

	assign adv       = !v_s2 || !full;
	assign vtx.ready = adv;
	assign push      = v_s2 && !full;
	assign push_word = word_s2;

	assign vin[0] = $signed(vtx.vertex_x);
	assign vin[1] = $signed(vtx.vertex_y);
	assign vin[2] = $signed(vtx.vertex_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vtx.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= vtp_pkg::cmd_t'(vtx.command);
			for (int r = 0; r < vtp_pkg::NUM_ROWS; r++) begin
				for (int c = 0; c < vtp_pkg::NUM_LANES; c++) begin
					prod_s1[r][c] <= $signed(matrix[r*vtp_pkg::NUM_ROWS+c]) * vin[c];
				end
				// rotate-only drops the translation column
				trans_s1[r] <= (vtp_pkg::cmd_t'(vtx.command) == vtp_pkg::CMD_ROTATE) ?
					'0 : $signed(matrix[r*vtp_pkg::NUM_ROWS+vtp_pkg::NUM_LANES]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2.cmd <= cmd_s1;
			for (int r = 0; r < vtp_pkg::NUM_ROWS; r++) begin
				word_s2.sum[r] <= vtp_pkg::ACC_W'(prod_s1[r][0])
					+ vtp_pkg::ACC_W'(prod_s1[r][1])
					+ vtp_pkg::ACC_W'(prod_s1[r][2])
					+ (vtp_pkg::ACC_W'(trans_s1[r]) <<< FRAC_BITS);
			end
		end
	end

endmodule

/* rtl/vtp_queue.sv */
// ----------------------------------------------------------------------------
// vtp_queue
// Short FIFO of row-sum words between the front and the back.
// ----------------------------------------------------------------------------
module vtp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vtp_pkg::sums_t push_word,
	output logic           full,
	input  logic           pop,
	output vtp_pkg::sums_t head,
	output logic           empty
);

	vtp_pkg::sums_t mem_q [vtp_pkg::QDEPTH];
	logic [vtp_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [vtp_pkg::QCNT_W-1:0] cnt_q;
	logic do_pop;

	assign full   = (cnt_q == vtp_pkg::QCNT_W'(vtp_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign head   = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + vtp_pkg::QCNT_W'(push) - vtp_pkg::QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

endmodule

/* rtl/vtp_back.sv */
// ----------------------------------------------------------------------------
// vtp_back
// Takes row sums from the queue, divides by w one quotient bit per stage
// (not for rotate-only), clamps and registers the result.
// ----------------------------------------------------------------------------
module vtp_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  vtp_pkg::sums_t head,
	input  logic           empty,
	output logic           pop,
	vtp_out_if.source      res
);

	localparam int STEPS = vtp_pkg::QUO_W;

	logic adv;
	logic v_s1;
	vtp_pkg::div_t d_s1;
	logic          step_v_s [STEPS+1];
	vtp_pkg::div_t step_s   [STEPS+1];
	logic          out_v_q;
	logic [vtp_pkg::COORD_W-1:0] out_q [vtp_pkg::NUM_LANES];
	logic out_dz_q, out_sat_q;

	assign adv = !out_v_q || res.ready;
	assign pop = adv;

	// sign and magnitude of the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= !empty;
	end

	always_ff @(posedge clk) begin
		logic signed [vtp_pkg::ACC_W-1:0] s;
		logic signed [vtp_pkg::ACC_W-1:0] w;
		logic wn;
		if (adv) begin
			w  = $signed(head.sum[vtp_pkg::W_ROW]);
			wn = w[vtp_pkg::ACC_W-1];
			d_s1.cmd   <= head.cmd;
			d_s1.wzero <= (w == '0);
			d_s1.den   <= vtp_pkg::MAG_W'(wn ? -w : w);
			d_s1.ovf   <= '0;
			d_s1.rem   <= '0;
			d_s1.quo   <= '0;
			for (int l = 0; l < vtp_pkg::NUM_LANES; l++) begin
				s = $signed(head.sum[l]);
				d_s1.mag[l] <= vtp_pkg::MAG_W'(s[vtp_pkg::ACC_W-1] ? -s : s);
				d_s1.neg[l] <= (head.cmd == vtp_pkg::CMD_FULL) ?
					(s[vtp_pkg::ACC_W-1] ^ wn) : s[vtp_pkg::ACC_W-1];
			end
		end
	end

	// divider valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) step_v_s[k] <= 1'b0;
		end else if (adv) begin
			step_v_s[0] <= v_s1;
			for (int k = 1; k <= STEPS; k++) step_v_s[k] <= step_v_s[k-1];
		end
	end

	// first stage: top bits of the numerator and the overflow check,
	// then one restoring step per stage
	always_ff @(posedge clk) begin
		logic [vtp_pkg::MAG_W-1:0] r0;
		logic [vtp_pkg::MAG_W:0]   t;
		logic                      nbit;
		vtp_pkg::div_t             dv;
		if (adv) begin
			dv = d_s1;
			for (int l = 0; l < vtp_pkg::NUM_LANES; l++) begin
				r0 = dv.mag[l] >> (vtp_pkg::QUO_W - FRAC_BITS);
				dv.rem[l] = r0;
				dv.ovf[l] = (r0 >= dv.den);
				dv.quo[l] = '0;
			end
			step_s[0] <= dv;
			for (int k = 1; k <= STEPS; k++) begin
				dv = step_s[k-1];
				for (int l = 0; l < vtp_pkg::NUM_LANES; l++) begin
					nbit = 1'b0;
					if (STEPS - k >= FRAC_BITS) nbit = dv.mag[l][STEPS - k - FRAC_BITS];
					t = {dv.rem[l], nbit};
					if (t >= {1'b0, dv.den}) begin
						dv.rem[l]            = vtp_pkg::MAG_W'(t - {1'b0, dv.den});
						dv.quo[l][STEPS - k] = 1'b1;
					end else begin
						dv.rem[l] = vtp_pkg::MAG_W'(t);
					end
				end
				step_s[k] <= dv;
			end
		end
	end

	// clamp and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= step_v_s[STEPS];
	end

	always_ff @(posedge clk) begin
		logic [vtp_pkg::MAG_W-1:0]   m;
		logic [vtp_pkg::COORD_W-1:0] lim;
		logic [vtp_pkg::COORD_W-1:0] low;
		logic                        sat;
		logic                        any_sat;
		vtp_pkg::div_t               d;
		if (adv) begin
			d = step_s[STEPS];
			any_sat = 1'b0;
			for (int l = 0; l < vtp_pkg::NUM_LANES; l++) begin
				lim = d.neg[l] ? vtp_pkg::NEG_LIMIT : vtp_pkg::POS_LIMIT;
				if (d.cmd == vtp_pkg::CMD_ROTATE) begin
					m   = d.mag[l] >> FRAC_BITS;
					sat = (m > vtp_pkg::MAG_W'(lim));
					low = m[vtp_pkg::COORD_W-1:0];
				end else begin
					sat = d.ovf[l] || (d.quo[l] > lim);
					low = d.quo[l];
				end
				if (d.cmd == vtp_pkg::CMD_FULL && d.wzero) begin
					out_q[l] <= '0;
				end else if (sat) begin
					out_q[l] <= lim;
				end else begin
					out_q[l] <= d.neg[l] ? -low : low;
				end
				any_sat = any_sat || sat;
			end
			out_dz_q  <= (d.cmd == vtp_pkg::CMD_FULL) && d.wzero;
			out_sat_q <= any_sat && !((d.cmd == vtp_pkg::CMD_FULL) && d.wzero);
		end
	end

	assign res.valid          = out_v_q;
	assign res.out_x          = out_q[0];
	assign res.out_y          = out_q[1];
	assign res.out_z          = out_q[2];
	assign res.divide_by_zero = out_dz_q;
	assign res.saturated      = out_sat_q;

endmodule

/* rtl/vertex_transform_project.sv */
// ----------------------------------------------------------------------------
// vertex_transform_project
// Homogeneous 4x4 vertex transform with perspective divide, Q16.16.
// ----------------------------------------------------------------------------
// One vertex is taken per clock and one result leaves per clock while the
// output is taken. Two front stages form the products and row sums, a
// four-word queue follows, then the back needs two stages for sign,
// magnitude and overflow check, 32 stages of a restoring divider (one
// quotient bit each, three lanes in parallel) and the output register. The
// user must write the matrix through cfg_we/cfg_index/cfg_data only while
// the block is empty; it does not enforce this. Reset loads the identity.
module vertex_transform_project #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vtp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [vtp_pkg::PAIR_W-1:0]   cfg_data,
	vtp_in_if.sink                       vtx,
	vtp_out_if.source                    res
);

	localparam logic [vtp_pkg::PAIR_W-1:0] ONE = vtp_pkg::PAIR_W'(1) << FRAC_BITS;

	logic [vtp_pkg::PAIR_W-1:0] pair_q [vtp_pkg::NUM_PAIRS];
	logic [vtp_pkg::NUM_ROWS*vtp_pkg::NUM_ROWS-1:0][vtp_pkg::COORD_W-1:0] matrix;
	logic           push, full, pop, empty;
	vtp_pkg::sums_t push_word, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < vtp_pkg::NUM_PAIRS; p++) pair_q[p] <= '0;
			pair_q[0] <= ONE;
			pair_q[2] <= ONE << vtp_pkg::COORD_W;
			pair_q[5] <= ONE;
			pair_q[7] <= ONE << vtp_pkg::COORD_W;
		end else if (cfg_we) begin
			pair_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int e = 0; e < vtp_pkg::NUM_ROWS*vtp_pkg::NUM_ROWS; e++) begin
			matrix[e] = pair_q[e/2][(e%2)*vtp_pkg::COORD_W +: vtp_pkg::COORD_W];
		end
	end

	vtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.matrix    (matrix),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	vtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	vtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

endmodule
